// ===== sv/i2a_pkg.sv =====
`default_nettype none

package i2a_pkg;

  // field widths
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned CHARS_PER_WORD = 8;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned BYTE_IDX_W     = 3;

  // digit register: twenty bcd digits cover any 64-bit magnitude
  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned DIG_W      = BCD_DIGITS * 4;
  localparam int unsigned NUM_W      = 7;
  localparam int unsigned ITER_W     = 6;

  // kind field layout
  localparam int unsigned KIND_UNSIGNED_BIT = 0;

  // digit counts after load, per radix
  localparam logic [NUM_W-1:0] DIGITS_DEC = NUM_W'(BCD_DIGITS);
  localparam logic [NUM_W-1:0] DIGITS_BIN = NUM_W'(64);
  localparam logic [NUM_W-1:0] DIGITS_OCT = NUM_W'(22);
  localparam logic [NUM_W-1:0] DIGITS_HEX = NUM_W'(16);

  localparam logic [ITER_W-1:0] DABBLE_LAST = ITER_W'(VALUE_W - 1);

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_TEN     = 8'd10;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_BIN,
    RADIX_OCT,
    RADIX_HEX
  } radix_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DABBLE,
    ST_SKIP,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    DU_HOLD,
    DU_LOAD,
    DU_DABBLE,
    DU_SHIFT
  } du_op_e;

  // sequencer to digit unit
  typedef struct packed {
    du_op_e op;
    radix_e radix;
  } du_ctrl_t;

  // sequencer to packer: one character
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_t;

  function automatic logic [NUM_W-1:0] digit_count(input radix_e r);
    logic [NUM_W-1:0] n;
    case (r)
      RADIX_DEC: n = DIGITS_DEC;
      RADIX_BIN: n = DIGITS_BIN;
      RADIX_OCT: n = DIGITS_OCT;
      RADIX_HEX: n = DIGITS_HEX;
      default:   n = DIGITS_DEC;
    endcase
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic up);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0000, d};
    end else if (up) begin
      c = CHAR_UPPER_A + {4'b0000, d} - CHAR_TEN;
    end else begin
      c = CHAR_LOWER_A + {4'b0000, d} - CHAR_TEN;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/i2a_in_if.sv =====
`default_nettype none

interface i2a_in_if
  import i2a_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [KIND_W-1:0]  kind;
  logic               upper_case;

  modport source (output valid, output value, output kind, output upper_case, input ready);
  modport sink   (input valid, input value, input kind, input upper_case, output ready);
endinterface

`default_nettype wire

// ===== sv/i2a_out_if.sv =====
`default_nettype none

interface i2a_out_if
  import i2a_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] text_word;
  logic [CNT_W-1:0]  char_count;
  logic              last;

  modport source (output valid, output text_word, output char_count, output last, input ready);
  modport sink   (input valid, input text_word, input char_count, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/integer_to_ascii_radix.sv =====
// flow: after the number word is taken, a leading minus sign is sent for a negative signed value,
//   a decimal value then runs 64 shift-and-add-3 steps, and the 20, 64, 22 or 16 digit slots for
//   decimal, binary, octal or hex are walked with leading zeros skipped; output stalls hold it
// input ready only while the sequencer is idle, so a new number is taken only once the last
//   character of the previous one has been taken by the packer
// reset: asynchronous active low, clears the sequencer, the packer and the output valid
`default_nettype none

module integer_to_ascii_radix
  import i2a_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  i2a_in_if.sink    in_i,
  i2a_out_if.source out_o
);

  state_e              state_q, state_d;
  radix_e              radix_q, radix_d;
  logic                upper_q, upper_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic                accept;
  logic                neg;
  radix_e              in_radix;
  logic [VALUE_W-1:0]  mag;
  logic [3:0]          digit;
  logic                char_ready;
  du_ctrl_t            du_ctrl;
  char_t               char_s;

  assign accept   = in_i.valid && in_i.ready;
  assign neg      = !in_i.kind[KIND_UNSIGNED_BIT] && in_i.value[VALUE_W-1];
  assign in_radix = radix_e'(in_i.kind[2:1]);
  assign mag      = neg ? (~in_i.value + VALUE_W'(1)) : in_i.value;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (neg) begin
            state_d = ST_SIGN;
          end else if (in_radix == RADIX_DEC) begin
            state_d = ST_DABBLE;
          end else begin
            state_d = ST_SKIP;
          end
        end
      end
      ST_SIGN: begin
        if (char_ready) begin
          state_d = (radix_q == RADIX_DEC) ? ST_DABBLE : ST_SKIP;
        end
      end
      ST_DABBLE: begin
        if (iter_q == DABBLE_LAST) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!(num_q > NUM_W'(1) && digit == 4'd0)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (char_ready && num_q == NUM_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    radix_d        = radix_q;
    upper_d        = upper_q;
    num_d          = num_q;
    iter_d         = iter_q;
    du_ctrl.op     = DU_HOLD;
    du_ctrl.radix  = radix_q;
    char_s.valid   = 1'b0;
    char_s.code    = CHAR_MINUS;
    char_s.last    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          radix_d       = in_radix;
          upper_d       = in_i.upper_case;
          num_d         = digit_count(in_radix);
          iter_d        = '0;
          du_ctrl.op    = DU_LOAD;
          du_ctrl.radix = in_radix;
        end
      end
      ST_SIGN: begin
        char_s.valid = 1'b1;
      end
      ST_DABBLE: begin
        du_ctrl.op = DU_DABBLE;
        iter_d     = iter_q + ITER_W'(1);
      end
      ST_SKIP: begin
        if (num_q > NUM_W'(1) && digit == 4'd0) begin
          du_ctrl.op = DU_SHIFT;
          num_d      = num_q - NUM_W'(1);
        end
      end
      ST_EMIT: begin
        char_s.valid = 1'b1;
        char_s.code  = digit_char(digit, upper_q);
        char_s.last  = (num_q == NUM_W'(1));
        if (char_ready) begin
          du_ctrl.op = DU_SHIFT;
          num_d      = num_q - NUM_W'(1);
        end
      end
      default: begin
        du_ctrl.op = DU_HOLD;
      end
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      num_q   <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      num_q   <= num_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
    upper_q <= upper_d;
  end

  i2a_digit_unit u_digit (
    .clk_i  (clk_i),
    .ctrl_i (du_ctrl),
    .mag_i  (mag),
    .digit_o(digit)
  );

  i2a_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_s),
    .char_ready_o(char_ready),
    .out_o       (out_o)
  );

  // digit counter never runs dry while digits are still being walked
  a_num_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SKIP || state_q == ST_EMIT) |-> num_q != '0)
    else $error("digit counter empty during skip or emit");

  // decimal conversion always runs the full 64 shift-and-add-3 steps
  a_dabble_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DABBLE && state_d == ST_SKIP) |-> iter_q == DABBLE_LAST)
    else $error("decimal conversion left early");

  // bcd digits stay in range once emitted
  a_bcd_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && radix_q == RADIX_DEC) |-> digit <= 4'd9)
    else $error("bcd digit out of range");

  // an accepted word starts the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("sequencer idle after accepting a word");

endmodule

`default_nettype wire

// ===== sv/i2a_digit_unit.sv =====
`default_nettype none

module i2a_digit_unit
  import i2a_pkg::*;
(
  input  wire logic               clk_i,
  input  wire du_ctrl_t           ctrl_i,
  input  wire logic [VALUE_W-1:0] mag_i,
  output logic [3:0]              digit_o
);

  logic [DIG_W-1:0]   dig_q, dig_d;
  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [DIG_W-1:0]   dig_adj;

  // add-3 correction on every bcd digit
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (dig_q[4*i +: 4] >= 4'd5) begin
        dig_adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
      end else begin
        dig_adj[4*i +: 4] = dig_q[4*i +: 4];
      end
    end
  end

  // shared load / shift-and-add-3 / digit shift unit
  always_comb begin
    dig_d = dig_q;
    bin_d = bin_q;
    case (ctrl_i.op)
      DU_LOAD: begin
        bin_d = mag_i;
        case (ctrl_i.radix)
          RADIX_DEC: dig_d = '0;
          RADIX_OCT: dig_d = {2'b00, mag_i, 14'b0};
          default:   dig_d = {mag_i, 16'b0};
        endcase
      end
      DU_DABBLE: begin
        dig_d = {dig_adj[DIG_W-2:0], bin_q[VALUE_W-1]};
        bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      end
      DU_SHIFT: begin
        case (ctrl_i.radix)
          RADIX_BIN: dig_d = {dig_q[DIG_W-2:0], 1'b0};
          RADIX_OCT: dig_d = {dig_q[DIG_W-4:0], 3'b000};
          default:   dig_d = {dig_q[DIG_W-5:0], 4'b0000};
        endcase
      end
      default: begin
        dig_d = dig_q;
        bin_d = bin_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    bin_q <= bin_d;
  end

  // leading digit, left aligned
  always_comb begin
    case (ctrl_i.radix)
      RADIX_BIN: digit_o = {3'b000, dig_q[DIG_W-1]};
      RADIX_OCT: digit_o = {1'b0, dig_q[DIG_W-1 -: 3]};
      default:   digit_o = dig_q[DIG_W-1 -: 4];
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/i2a_packer.sv =====
`default_nettype none

module i2a_packer
  import i2a_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire char_t char_i,
  output logic       char_ready_o,
  i2a_out_if.source  out_o
);

  logic [WORD_W-1:0] pack_q, pack_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              valid_q, valid_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [CNT_W-1:0]  wcnt_q, wcnt_d;
  logic              last_q, last_d;
  logic [CNT_W-1:0]  cnt_inc;
  logic              flush;
  logic              take;
  logic [WORD_W-1:0] merged;

  assign cnt_inc = cnt_q + CNT_W'(1);
  assign flush   = char_i.last || (cnt_inc == CNT_W'(CHARS_PER_WORD));
  assign char_ready_o = !(flush && valid_q && !out_o.ready);
  assign take    = char_i.valid && char_ready_o;
  assign merged  = pack_q |
                   ({{(WORD_W-CHAR_W){1'b0}}, char_i.code} << {cnt_q[BYTE_IDX_W-1:0], 3'b000});

  // gather characters, hand a full or final word to the output register
  always_comb begin
    pack_d  = pack_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    wcnt_d  = wcnt_q;
    last_d  = last_q;
    valid_d = valid_q && !out_o.ready;
    if (take) begin
      if (flush) begin
        pack_d  = '0;
        cnt_d   = '0;
        word_d  = merged;
        wcnt_d  = cnt_inc;
        last_d  = char_i.last;
        valid_d = 1'b1;
      end else begin
        pack_d = merged;
        cnt_d  = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q  <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pack_q  <= pack_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    wcnt_q <= wcnt_d;
    last_q <= last_d;
  end

  assign out_o.valid      = valid_q;
  assign out_o.text_word  = word_q;
  assign out_o.char_count = wcnt_q;
  assign out_o.last       = last_q;

endmodule

`default_nettype wire
